// ===== rtl/core/tng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus neighbor generator package
// Shared widths, register indexes and the per-dimension settings type.
// ----------------------------------------------------------------------------
package tng_pkg;

    localparam int DIM_SLOTS = 5;
    localparam int COORD_W   = 4;
    localparam int SIZE_W    = 5;
    localparam int ID_W      = 20;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_SIZE_A = 3'd0,
        REG_DIM_SIZE_B = 3'd1,
        REG_DIM_SIZE_C = 3'd2,
        REG_DIM_SIZE_D = 3'd3,
        REG_DIM_SIZE_E = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   stride;
        logic [ID_W-1:0]   wrap;
        logic              has_minus;
        logic              has_plus;
    } t_lane_cfg;

endpackage

// ===== rtl/core/tng_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus neighbor generator channels
// Node request, neighbor result and register write channels.
// ----------------------------------------------------------------------------
interface tng_req_if;
    import tng_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_a;
    logic [COORD_W-1:0] coord_b;
    logic [COORD_W-1:0] coord_c;
    logic [COORD_W-1:0] coord_d;
    logic [COORD_W-1:0] coord_e;

    modport source (output valid, coord_a, coord_b, coord_c, coord_d, coord_e, input ready);
    modport sink (input valid, coord_a, coord_b, coord_c, coord_d, coord_e, output ready);
endinterface

interface tng_rsp_if;
    import tng_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] source_id;
    logic [ID_W-1:0] neighbor_id;
    logic            last;

    modport source (output valid, source_id, neighbor_id, last, input ready);
    modport sink (input valid, source_id, neighbor_id, last, output ready);
endinterface

interface tng_cfg_if;
    import tng_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tng_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus neighbor generator configuration
// Holds the dimension sizes and derives each dimension's stride and wrap step.
// ----------------------------------------------------------------------------
module tng_cfg #(
    parameter int DIM_COUNT    = 5,
    parameter int MAX_DIM_SIZE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tng_cfg_if.sink            i_cfg,
    output tng_pkg::t_lane_cfg o_lane [DIM_COUNT],
    output logic               o_settled
);
    import tng_pkg::*;

    localparam int SETTLE_CYC = DIM_COUNT + 1;
    localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

    logic [SIZE_W-1:0]   r_size [DIM_SLOTS];
    logic [SIZE_W-1:0]   w_eff [DIM_COUNT];
    logic [ID_W-1:0]     r_stride [DIM_COUNT];
    logic [ID_W-1:0]     n_stride [DIM_COUNT];
    logic [ID_W-1:0]     r_wrap [DIM_COUNT];
    logic [SETTLE_W-1:0] r_settle;
    logic                w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;
    assign o_settled   = (r_settle == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIM_SLOTS; k++) begin
                r_size[k] <= SIZE_W'(2);
            end
            r_settle <= SETTLE_W'(SETTLE_CYC);
        end else if (w_wr) begin
            case (i_cfg.index)
                REG_DIM_SIZE_A: r_size[0] <= i_cfg.data;
                REG_DIM_SIZE_B: r_size[1] <= i_cfg.data;
                REG_DIM_SIZE_C: r_size[2] <= i_cfg.data;
                REG_DIM_SIZE_D: r_size[3] <= i_cfg.data;
                REG_DIM_SIZE_E: r_size[4] <= i_cfg.data;
                default: ;
            endcase
            r_settle <= SETTLE_W'(SETTLE_CYC);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < DIM_COUNT; k++) begin
            if (r_size[k] == '0) begin
                w_eff[k] = SIZE_W'(1);
            end else if (r_size[k] > SIZE_W'(MAX_DIM_SIZE)) begin
                w_eff[k] = SIZE_W'(MAX_DIM_SIZE);
            end else begin
                w_eff[k] = r_size[k];
            end
        end
        for (int k = 0; k < DIM_COUNT - 1; k++) begin
            n_stride[k] = ID_W'(r_stride[k+1] * ID_W'(w_eff[k+1]));
        end
        n_stride[DIM_COUNT-1] = ID_W'(1);
    end

    // The stride chain settles one dimension per cycle after a size change.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIM_COUNT; k++) begin
            r_stride[k] <= n_stride[k];
            r_wrap[k]   <= ID_W'(r_stride[k] * ID_W'(w_eff[k] - SIZE_W'(1)));
        end
    end

    always_comb begin
        for (int k = 0; k < DIM_COUNT; k++) begin
            o_lane[k].size      = w_eff[k];
            o_lane[k].stride    = r_stride[k];
            o_lane[k].wrap      = r_wrap[k];
            o_lane[k].has_minus = (w_eff[k] >= SIZE_W'(2));
            o_lane[k].has_plus  = (w_eff[k] >= SIZE_W'(3));
        end
    end

endmodule

// ===== rtl/core/tng_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus neighbor generator lane
// Weights one coordinate and forms the minus and plus neighbor ids of its
// dimension.
// ----------------------------------------------------------------------------
module tng_lane (
    input  logic                        i_clk,
    input  logic                        i_en_b,
    input  logic                        i_en_c,
    input  logic                        i_en_d,
    input  logic [tng_pkg::COORD_W-1:0] i_coord,
    input  tng_pkg::t_lane_cfg          i_cfg,
    input  logic [tng_pkg::ID_W-1:0]    i_src,
    output logic [tng_pkg::ID_W-1:0]    o_term,
    output logic [tng_pkg::ID_W-1:0]    o_minus_id,
    output logic [tng_pkg::ID_W-1:0]    o_plus_id
);
    import tng_pkg::*;

    logic [COORD_W-1:0] w_coord;
    logic               w_zero;
    logic               w_top;
    logic [ID_W-1:0]    r_term;
    logic               r_zero_b;
    logic               r_top_b;
    logic               r_zero_c;
    logic               r_top_c;
    logic [ID_W-1:0]    r_minus;
    logic [ID_W-1:0]    r_plus;

    always_comb begin
        if ({1'b0, i_coord} >= i_cfg.size) begin
            w_coord = COORD_W'(i_cfg.size - SIZE_W'(1));
        end else begin
            w_coord = i_coord;
        end
        w_zero = (w_coord == '0);
        w_top  = (({1'b0, w_coord} + SIZE_W'(1)) >= i_cfg.size);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_term   <= ID_W'(i_cfg.stride * ID_W'(w_coord));
            r_zero_b <= w_zero;
            r_top_b  <= w_top;
        end
        if (i_en_c) begin
            r_zero_c <= r_zero_b;
            r_top_c  <= r_top_b;
        end
        if (i_en_d) begin
            r_minus <= r_zero_c ? (i_src + i_cfg.wrap) : (i_src - i_cfg.stride);
            r_plus  <= r_top_c ? (i_src - i_cfg.wrap) : (i_src + i_cfg.stride);
        end
    end

    assign o_term     = r_term;
    assign o_minus_id = r_minus;
    assign o_plus_id  = r_plus;

endmodule

// ===== rtl/core/tng_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus neighbor generator merge
// Collects a node's lane results, issuing one per cycle while o_rsp is ready.
// ----------------------------------------------------------------------------
module tng_merge #(
    parameter int DIM_COUNT = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [tng_pkg::ID_W-1:0] i_src,
    input  logic [tng_pkg::ID_W-1:0] i_ids [2*DIM_COUNT],
    input  logic [2*DIM_COUNT-1:0]   i_mask,
    output logic                     o_ready,
    tng_rsp_if.source                o_rsp
);
    import tng_pkg::*;

    localparam int NRES = 2 * DIM_COUNT;

    logic [ID_W-1:0] r_ids [NRES];
    logic [ID_W-1:0] r_src;
    logic [NRES-1:0] r_mask;
    logic [NRES-1:0] w_sel;
    logic [NRES-1:0] w_rest;
    logic [ID_W-1:0] w_id;
    logic            w_fire;
    logic            w_load;

    always_comb begin
        w_sel  = r_mask & (~r_mask + NRES'(1));
        w_rest = r_mask & ~w_sel;
        w_id   = '0;
        for (int i = 0; i < NRES; i++) begin
            if (w_sel[i]) begin
                w_id = w_id | r_ids[i];
            end
        end
    end

    assign o_rsp.valid       = |r_mask;
    assign o_rsp.source_id   = r_src;
    assign o_rsp.neighbor_id = w_id;
    assign o_rsp.last        = (w_rest == '0);

    assign w_fire  = o_rsp.valid && o_rsp.ready;
    assign o_ready = !(|r_mask) || (w_fire && (w_rest == '0));
    assign w_load  = i_vld && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (w_load) begin
            r_mask <= i_mask;
        end else if (w_fire) begin
            r_mask <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_src <= i_src;
            for (int i = 0; i < NRES; i++) begin
                r_ids[i] <= i_ids[i];
            end
        end
    end

endmodule

// ===== rtl/core/torus_neighbor_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus neighbor generator
// A request passes lane weighting, source sum, neighbor and merge registers.
// Throughput: one result per cycle while o_rsp.ready is high, set by the
// single result port of the merge stage.
// Reset: sizes return to 2; requests are held off after reset and after each
// register write while the strides settle.
// ----------------------------------------------------------------------------
module torus_neighbor_generator #(
    parameter int DIM_COUNT    = 5,
    parameter int MAX_DIM_SIZE = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tng_req_if.sink   i_req,
    tng_rsp_if.source o_rsp,
    tng_cfg_if.sink   i_cfg
);
    import tng_pkg::*;

    t_lane_cfg          w_lane_cfg [DIM_COUNT];
    logic               w_settled;
    logic [COORD_W-1:0] w_coord [DIM_SLOTS];
    logic [ID_W-1:0]    w_term [DIM_COUNT];
    logic [ID_W-1:0]    w_minus [DIM_COUNT];
    logic [ID_W-1:0]    w_plus [DIM_COUNT];
    logic [ID_W-1:0]    w_ids [2*DIM_COUNT];
    logic [2*DIM_COUNT-1:0] w_mask;
    logic [ID_W-1:0]    w_sum;
    logic [ID_W-1:0]    r_src_c;
    logic [ID_W-1:0]    r_src_d;
    logic               r_vld_b;
    logic               r_vld_c;
    logic               r_vld_d;
    logic               w_rdy_b;
    logic               w_rdy_c;
    logic               w_rdy_d;
    logic               w_merge_rdy;
    logic               w_en_b;
    logic               w_en_c;
    logic               w_en_d;

    tng_cfg #(
        .DIM_COUNT    (DIM_COUNT),
        .MAX_DIM_SIZE (MAX_DIM_SIZE)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_lane    (w_lane_cfg),
        .o_settled (w_settled)
    );

    assign w_coord[0] = i_req.coord_a;
    assign w_coord[1] = i_req.coord_b;
    assign w_coord[2] = i_req.coord_c;
    assign w_coord[3] = i_req.coord_d;
    assign w_coord[4] = i_req.coord_e;

    assign w_rdy_d     = !r_vld_d || w_merge_rdy;
    assign w_rdy_c     = !r_vld_c || w_rdy_d;
    assign w_rdy_b     = !r_vld_b || w_rdy_c;
    assign i_req.ready = w_rdy_b && w_settled;
    assign w_en_b      = i_req.valid && i_req.ready;
    assign w_en_c      = r_vld_b && w_rdy_c;
    assign w_en_d      = r_vld_c && w_rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (w_rdy_b) begin
                r_vld_b <= w_en_b;
            end
            if (w_rdy_c) begin
                r_vld_c <= r_vld_b;
            end
            if (w_rdy_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    for (genvar k = 0; k < DIM_COUNT; k++) begin : g_lane
        tng_lane u_lane (
            .i_clk      (i_clk),
            .i_en_b     (w_en_b),
            .i_en_c     (w_en_c),
            .i_en_d     (w_en_d),
            .i_coord    (w_coord[k]),
            .i_cfg      (w_lane_cfg[k]),
            .i_src      (r_src_c),
            .o_term     (w_term[k]),
            .o_minus_id (w_minus[k]),
            .o_plus_id  (w_plus[k])
        );
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < DIM_COUNT; k++) begin
            w_sum = w_sum + w_term[k];
        end
        for (int k = 0; k < DIM_COUNT; k++) begin
            w_ids[2*k]      = w_minus[k];
            w_ids[2*k+1]    = w_plus[k];
            w_mask[2*k]     = w_lane_cfg[k].has_minus;
            w_mask[2*k+1]   = w_lane_cfg[k].has_plus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_src_c <= w_sum;
        end
        if (w_en_d) begin
            r_src_d <= r_src_c;
        end
    end

    tng_merge #(
        .DIM_COUNT (DIM_COUNT)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_d),
        .i_src   (r_src_d),
        .i_ids   (w_ids),
        .i_mask  (w_mask),
        .o_ready (w_merge_rdy),
        .o_rsp   (o_rsp)
    );

endmodule
